FILE: hw/rtl/bba_pkg.sv
// shared types and constants of the buddy block allocator
package bba_pkg;

	localparam int unsigned REQ_W = 11;
	localparam int unsigned OFF_W = 10;
	localparam int unsigned KW    = 5;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		RSP_OK      = 2'd0,
		RSP_NOSPACE = 2'd1,
		RSP_BAD     = 2'd2,
		RSP_UNDEF   = 2'd3
	} rsp_status_t;

	typedef enum logic [1:0] {
		NODE_UNUSED = 2'd0,
		NODE_FREE   = 2'd1,
		NODE_ALLOC  = 2'd2,
		NODE_SPLIT  = 2'd3
	} node_st_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [REQ_W-1:0] request_size;
		logic [OFF_W-1:0] block_offset;
	} req_t;

	typedef struct packed {
		rsp_status_t      status;
		logic [OFF_W-1:0] granted_offset;
		logic [REQ_W-1:0] granted_size;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_A_EVAL,
		S_A_RD,
		S_A_SPL,
		S_A_SPL2,
		S_A_GRANT,
		S_A_BT,
		S_F_EVAL,
		S_F_LOOP,
		S_F_SIB,
		S_F_MRG,
		S_F_DONE
	} state_t;

	typedef enum logic [1:0] {
		MEM_NONE,
		MEM_RD,
		MEM_WR,
		MEM_CLR
	} mem_op_t;

	typedef enum logic [1:0] {
		MV_NONE,
		MV_DOWN,
		MV_UP,
		MV_NEXT
	} move_t;

	typedef enum logic [1:0] {
		RESP_NONE,
		RESP_GIVE_OK,
		RESP_GIVE_NOSPACE,
		RESP_GIVE_BAD
	} resp_op_t;

	typedef struct packed {
		logic     load;
		mem_op_t  mem_op;
		logic     sib;
		node_st_t wdata;
		move_t    move;
		resp_op_t resp;
	} dp_cmd_t;

	typedef struct packed {
		node_st_t rd_st;
		logic     lv_eq;
		logic     root;
		logic     odd;
		logic     bad;
		logic     is_free;
		logic     clr_last;
	} dp_stat_t;

endpackage

FILE: hw/rtl/bba_ctrl.sv
// controller state machine of the buddy block allocator
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t  dcmd
);

	bba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::S_CLEAR:   if (stat.clr_last) state_d = bba_pkg::S_IDLE;
			bba_pkg::S_IDLE:    if (start) state_d = bba_pkg::S_CHECK;
			bba_pkg::S_CHECK: begin
				if (stat.bad) state_d = bba_pkg::S_IDLE;
				else if (stat.is_free) state_d = bba_pkg::S_F_EVAL;
				else state_d = bba_pkg::S_A_EVAL;
			end
			bba_pkg::S_A_EVAL: begin
				if (stat.rd_st == bba_pkg::NODE_FREE && stat.lv_eq) begin
					state_d = bba_pkg::S_IDLE;
				end else if (stat.rd_st == bba_pkg::NODE_FREE) begin
					state_d = bba_pkg::S_A_SPL;
				end else if (stat.rd_st == bba_pkg::NODE_SPLIT && !stat.lv_eq) begin
					state_d = bba_pkg::S_A_RD;
				end else begin
					state_d = bba_pkg::S_A_BT;
				end
			end
			bba_pkg::S_A_RD:    state_d = bba_pkg::S_A_EVAL;
			bba_pkg::S_A_SPL:   state_d = bba_pkg::S_A_SPL2;
			bba_pkg::S_A_SPL2:  state_d = stat.lv_eq ? bba_pkg::S_A_GRANT : bba_pkg::S_A_SPL;
			bba_pkg::S_A_GRANT: state_d = bba_pkg::S_IDLE;
			bba_pkg::S_A_BT: begin
				if (stat.root) state_d = bba_pkg::S_IDLE;
				else if (!stat.odd) state_d = bba_pkg::S_A_RD;
			end
			bba_pkg::S_F_EVAL: begin
				if (stat.rd_st != bba_pkg::NODE_ALLOC) state_d = bba_pkg::S_IDLE;
				else state_d = bba_pkg::S_F_LOOP;
			end
			bba_pkg::S_F_LOOP:  state_d = stat.root ? bba_pkg::S_F_DONE : bba_pkg::S_F_SIB;
			bba_pkg::S_F_SIB: begin
				if (stat.rd_st == bba_pkg::NODE_FREE) state_d = bba_pkg::S_F_MRG;
				else state_d = bba_pkg::S_F_DONE;
			end
			bba_pkg::S_F_MRG:   state_d = bba_pkg::S_F_LOOP;
			bba_pkg::S_F_DONE:  state_d = bba_pkg::S_IDLE;
			default:            state_d = bba_pkg::S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		dcmd        = '0;
		dcmd.mem_op = bba_pkg::MEM_NONE;
		dcmd.wdata  = bba_pkg::NODE_UNUSED;
		dcmd.move   = bba_pkg::MV_NONE;
		dcmd.resp   = bba_pkg::RESP_NONE;
		unique case (state_q)
			bba_pkg::S_CLEAR: dcmd.mem_op = bba_pkg::MEM_CLR;
			bba_pkg::S_IDLE:  dcmd.load = start;
			bba_pkg::S_CHECK: begin
				if (stat.bad) dcmd.resp = bba_pkg::RESP_GIVE_BAD;
				else dcmd.mem_op = bba_pkg::MEM_RD;
			end
			bba_pkg::S_A_EVAL: begin
				if (stat.rd_st == bba_pkg::NODE_FREE && stat.lv_eq) begin
					dcmd.mem_op = bba_pkg::MEM_WR;
					dcmd.wdata  = bba_pkg::NODE_ALLOC;
					dcmd.resp   = bba_pkg::RESP_GIVE_OK;
				end else if (stat.rd_st == bba_pkg::NODE_SPLIT && !stat.lv_eq
						&& stat.rd_st != bba_pkg::NODE_FREE) begin
					dcmd.move = bba_pkg::MV_DOWN;
				end
			end
			bba_pkg::S_A_RD: dcmd.mem_op = bba_pkg::MEM_RD;
			bba_pkg::S_A_SPL: begin
				dcmd.mem_op = bba_pkg::MEM_WR;
				dcmd.wdata  = bba_pkg::NODE_SPLIT;
				dcmd.move   = bba_pkg::MV_DOWN;
			end
			bba_pkg::S_A_SPL2: begin
				dcmd.mem_op = bba_pkg::MEM_WR;
				dcmd.sib    = 1'b1;
				dcmd.wdata  = bba_pkg::NODE_FREE;
			end
			bba_pkg::S_A_GRANT: begin
				dcmd.mem_op = bba_pkg::MEM_WR;
				dcmd.wdata  = bba_pkg::NODE_ALLOC;
				dcmd.resp   = bba_pkg::RESP_GIVE_OK;
			end
			bba_pkg::S_A_BT: begin
				if (stat.root) dcmd.resp = bba_pkg::RESP_GIVE_NOSPACE;
				else if (stat.odd) dcmd.move = bba_pkg::MV_UP;
				else dcmd.move = bba_pkg::MV_NEXT;
			end
			bba_pkg::S_F_EVAL: begin
				if (stat.rd_st != bba_pkg::NODE_ALLOC) dcmd.resp = bba_pkg::RESP_GIVE_BAD;
			end
			bba_pkg::S_F_LOOP: begin
				if (!stat.root) begin
					dcmd.mem_op = bba_pkg::MEM_RD;
					dcmd.sib    = 1'b1;
				end
			end
			bba_pkg::S_F_SIB: begin
				if (stat.rd_st == bba_pkg::NODE_FREE) begin
					dcmd.mem_op = bba_pkg::MEM_WR;
					dcmd.wdata  = bba_pkg::NODE_UNUSED;
				end
			end
			bba_pkg::S_F_MRG: begin
				dcmd.mem_op = bba_pkg::MEM_WR;
				dcmd.sib    = 1'b1;
				dcmd.wdata  = bba_pkg::NODE_UNUSED;
				dcmd.move   = bba_pkg::MV_UP;
			end
			bba_pkg::S_F_DONE: begin
				dcmd.mem_op = bba_pkg::MEM_WR;
				dcmd.wdata  = bba_pkg::NODE_FREE;
				dcmd.resp   = bba_pkg::RESP_GIVE_OK;
			end
			default: dcmd.resp = bba_pkg::RESP_NONE;
		endcase
	end

	assign busy = (state_q != bba_pkg::S_IDLE);

endmodule

FILE: hw/rtl/bba_dp.sv
// datapath of the buddy block allocator: node memory, walk registers, result
module bba_dp #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::req_t     request,
	input  bba_pkg::dp_cmd_t  dcmd,
	output bba_pkg::dp_stat_t stat,
	output logic              done,
	output bba_pkg::rsp_t     result
);

	localparam int unsigned L  = $clog2(LEAVES);
	localparam int unsigned AW = L + 1;
	localparam int unsigned CW = ((L + 2) > 13) ? (L + 2) : 13;

	logic [1:0]              mem [2**AW];
	logic [AW-1:0]           clr_q;
	logic [1:0]              rd_q;
	bba_pkg::cmd_t           cmd_q;
	logic [bba_pkg::REQ_W-1:0] req_q;
	logic [bba_pkg::OFF_W-1:0] off_q;
	logic [bba_pkg::KW-1:0]  k_q, lv_q, wl_q;
	logic [AW-1:0]           idx_q;
	logic                    done_q;
	bba_pkg::rsp_t           rsp_q;

	logic [bba_pkg::REQ_W-1:0] rm1;
	logic [bba_pkg::KW-1:0]  k_d, lv_d;
	logic [AW-1:0]           idx_free;
	logic [AW-1:0]           addr;
	logic [CW-1:0]           sz_w, end_w;
	logic [AW-1:0]           lv_mask, alloc_off;

	// size exponent is the bit length of request_size - 1
	always_comb begin
		rm1 = request.request_size - bba_pkg::REQ_W'(1);
		k_d = '0;
		for (int i = 0; i < bba_pkg::REQ_W; i++) begin
			if (rm1[i]) k_d = bba_pkg::KW'(i + 1);
		end
		lv_d     = bba_pkg::KW'(L) - k_d;
		idx_free = (AW'(1) << lv_d) | AW'(request.block_offset >> k_d);
	end

	assign addr = dcmd.sib ? (idx_q ^ AW'(1)) : idx_q;

	always_ff @(posedge clk) begin
		unique case (dcmd.mem_op)
			bba_pkg::MEM_CLR: mem[clr_q] <= (clr_q == AW'(1)) ? bba_pkg::NODE_FREE
				: bba_pkg::NODE_UNUSED;
			bba_pkg::MEM_WR:  mem[addr] <= dcmd.wdata;
			bba_pkg::MEM_RD:  rd_q <= mem[addr];
			default:          rd_q <= rd_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (dcmd.mem_op == bba_pkg::MEM_CLR) clr_q <= clr_q + AW'(1);
			done_q <= (dcmd.resp != bba_pkg::RESP_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q <= request.cmd;
			req_q <= request.request_size;
			off_q <= request.block_offset;
			k_q   <= k_d;
			wl_q  <= lv_d;
			lv_q  <= (request.cmd == bba_pkg::CMD_FREE) ? lv_d : '0;
			idx_q <= (request.cmd == bba_pkg::CMD_FREE) ? idx_free : AW'(1);
		end else begin
			unique case (dcmd.move)
				bba_pkg::MV_DOWN: begin
					idx_q <= {idx_q[AW-2:0], 1'b0};
					lv_q  <= lv_q + bba_pkg::KW'(1);
				end
				bba_pkg::MV_UP: begin
					idx_q <= idx_q >> 1;
					lv_q  <= lv_q - bba_pkg::KW'(1);
				end
				bba_pkg::MV_NEXT: idx_q <= idx_q + AW'(1);
				default:          idx_q <= idx_q;
			endcase
		end
	end

	// request checks, status to the controller and allocated offset
	always_comb begin
		sz_w  = CW'(1) << k_q;
		end_w = CW'(off_q) + sz_w;
		stat.bad = (req_q == '0) || (k_q > bba_pkg::KW'(L))
			|| (cmd_q == bba_pkg::CMD_FREE
				&& (((CW'(off_q) & (sz_w - CW'(1))) != '0) || (end_w > CW'(LEAVES))));
		stat.rd_st    = bba_pkg::node_st_t'(rd_q);
		stat.lv_eq    = (lv_q == wl_q);
		stat.root     = (idx_q == AW'(1));
		stat.odd      = idx_q[0];
		stat.is_free  = (cmd_q == bba_pkg::CMD_FREE);
		stat.clr_last = &clr_q;
		lv_mask   = (AW'(1) << lv_q) - AW'(1);
		alloc_off = (idx_q & lv_mask) << k_q;
	end

	always_ff @(posedge clk) begin
		unique case (dcmd.resp)
			bba_pkg::RESP_GIVE_OK: begin
				rsp_q.status         <= bba_pkg::RSP_OK;
				rsp_q.granted_offset <= (cmd_q == bba_pkg::CMD_FREE) ? off_q
					: bba_pkg::OFF_W'(alloc_off);
				rsp_q.granted_size   <= bba_pkg::REQ_W'(sz_w);
			end
			bba_pkg::RESP_GIVE_NOSPACE: begin
				rsp_q.status         <= bba_pkg::RSP_NOSPACE;
				rsp_q.granted_offset <= '0;
				rsp_q.granted_size   <= '0;
			end
			bba_pkg::RESP_GIVE_BAD: begin
				rsp_q.status         <= bba_pkg::RSP_BAD;
				rsp_q.granted_offset <= '0;
				rsp_q.granted_size   <= '0;
			end
			default: rsp_q <= rsp_q;
		endcase
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule

FILE: hw/rtl/buddy_block_allocator.sv
// top level of the buddy block allocator
// buddy allocator over LEAVES units held as a binary tree of 2-bit node states in one
// single-port memory of 2*LEAVES entries. after reset a clearing pass writes every entry,
// one per cycle, so busy stays high until the pass is done, before the first transaction is
// taken. a transaction is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high and cannot be held off by the receiver.
// each transaction is paced by the one memory access per cycle: a setup, then for an
// allocate a read per split node walked down, a write of each free node split and of its
// buddy, and a step over each node passed while backtracking; a free reads the sibling and
// writes both buddies per merge, and a bad request ends at the check.
// busy falls in the cycle in which the result is shown.
module buddy_block_allocator #(
	parameter int unsigned LEAVES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bba_pkg::req_t request,
	output logic          done,
	output bba_pkg::rsp_t result
);

	// command and status between controller and datapath
	bba_pkg::dp_cmd_t  dcmd;
	bba_pkg::dp_stat_t stat;

	// sequencer: clearing pass, tree descent with backtracking, merge ascent
	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.dcmd   (dcmd)
	);

	// node memory, walk index and level, request checks and result register
	bba_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.dcmd    (dcmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule
